/* hw/rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg : shared types and constants of the text clause chunker
// Field widths, item types, register indexes and reset values.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int LENGTH_BITS    = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int COUNT_BITS     = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_CHUNK_SIZE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_CHUNKS     = CFG_INDEX_BITS'(1);

    localparam logic [CFG_DATA_BITS-1:0] MAX_CHUNK_SIZE_RESET = CFG_DATA_BITS'(256);
    localparam logic [CFG_DATA_BITS-1:0] MAX_CHUNKS_RESET     = CFG_DATA_BITS'(65535);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] chunk_offset;
        logic [LENGTH_BITS-1:0] chunk_length;
        logic                   chunk_present;
        logic                   end_of_text;
    } chunk_item_t;

    // up to two result items written to the queue in one cycle
    typedef struct packed {
        logic [1:0]  count;
        chunk_item_t first;
        chunk_item_t second;
    } chunk_push_t;

endpackage

/* hw/rtl/tcc_core.sv */
// ----------------------------------------------------------------------------
// tcc_core : input register, split trackers and per-byte step logic
// Holds one text byte, decides splits from running trackers and hands up to
// two chunk items per byte to the result queue.
// ----------------------------------------------------------------------------
module tcc_core
    import tcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_stall,
    input  text_item_t                text,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      room,
    output chunk_push_t               push
);

    localparam int CMP_BITS = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    typedef logic [OFFSET_BITS-1:0] pos_t;

    typedef struct packed {
        pos_t                  byte_position;
        pos_t                  chunk_start;
        logic                  skipping_space;
        pos_t                  boundary_end;
        logic                  boundary_seen;
        pos_t                  first_text_after_boundary;
        logic                  text_after_boundary_seen;
        pos_t                  space_position;
        logic                  space_seen;
        pos_t                  nonspace_end;
        logic [COUNT_BITS-1:0] chunks_emitted;
    } track_t;

    localparam track_t TRACK_RESET = '{
        byte_position:             '0,
        chunk_start:               '0,
        skipping_space:            1'b1,
        boundary_end:              '0,
        boundary_seen:             1'b0,
        first_text_after_boundary: '0,
        text_after_boundary_seen:  1'b0,
        space_position:            '0,
        space_seen:                1'b0,
        nonspace_end:              '0,
        chunks_emitted:            '0
    };

    function automatic logic is_mark(input logic [7:0] c);
        return c == 8'h2C || c == 8'h2E || c == 8'h3F || c == 8'h21
            || c == 8'h3B || c == 8'h3A;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic track_t open_chunk(input track_t t, input pos_t at);
        track_t r;
        r                          = t;
        r.chunk_start              = at;
        r.skipping_space           = 1'b0;
        r.boundary_seen            = 1'b0;
        r.text_after_boundary_seen = 1'b0;
        r.space_seen               = 1'b0;
        r.nonspace_end             = at;
        return r;
    endfunction

    function automatic chunk_item_t make_chunk(input pos_t off, input pos_t len);
        chunk_item_t r;
        r.chunk_offset  = off;
        r.chunk_length  = (CMP_BITS'(len) > CMP_BITS'(LEN_MAX)) ? LEN_MAX
                                                                : LENGTH_BITS'(len);
        r.chunk_present = 1'b1;
        r.end_of_text   = 1'b0;
        return r;
    endfunction

    logic [CFG_DATA_BITS-1:0] max_chunk_size_reg;
    logic [CFG_DATA_BITS-1:0] max_chunks_reg;
    logic                     item_valid_reg;
    text_item_t               item_reg;
    track_t                   track_reg;
    track_t                   track_next;
    logic                     fire;
    logic                     accept;

    assign fire       = item_valid_reg && room;
    assign text_stall = item_valid_reg && !room;
    assign accept     = text_valid && !text_stall;

    always_comb
    begin
        track_t      t;
        logic [7:0]  c;
        pos_t        k;
        pos_t        nx;
        pos_t        len;
        pos_t        ft;
        logic        keep;
        logic [1:0]  n;
        chunk_item_t r0;
        chunk_item_t r1;
        chunk_item_t cand;

        t    = track_reg;
        c    = item_reg.text_byte;
        k    = t.byte_position;
        n    = 2'd0;
        r0   = '0;
        r1   = '0;
        cand = '0;
        nx   = k + pos_t'(1);
        len  = '0;
        ft   = '0;
        keep = 1'b0;

        // window full: split on bytes before the current one
        if (!t.skipping_space && max_chunk_size_reg != '0
            && (k - t.chunk_start) >= OFFSET_BITS'(max_chunk_size_reg))
        begin
            if (t.boundary_seen)
            begin
                cand = make_chunk(t.chunk_start, t.boundary_end - t.chunk_start);
            end
            else if (t.space_seen)
            begin
                cand = make_chunk(t.chunk_start, t.space_position - t.chunk_start);
            end
            else
            begin
                cand = make_chunk(t.chunk_start, k - t.chunk_start);
            end
            if (t.chunks_emitted < max_chunks_reg)
            begin
                r0               = cand;
                n                = 2'd1;
                t.chunks_emitted = t.chunks_emitted + COUNT_BITS'(1);
            end

            if (t.boundary_seen)
            begin
                if (t.text_after_boundary_seen)
                begin
                    ft   = t.first_text_after_boundary;
                    keep = t.space_seen
                        && (t.space_position - t.chunk_start) > (ft - t.chunk_start);
                    t.chunk_start              = ft;
                    t.boundary_seen            = 1'b0;
                    t.text_after_boundary_seen = 1'b0;
                    t.space_seen               = keep;
                end
                else if (!is_blank(c))
                begin
                    t = open_chunk(t, k);
                end
                else
                begin
                    t.skipping_space = 1'b1;
                end
            end
            else if (t.space_seen)
            begin
                nx = t.space_position + pos_t'(1);
                if (nx != k)
                begin
                    t              = open_chunk(t, nx);
                    t.nonspace_end = k;
                end
                else if (!is_blank(c))
                begin
                    t = open_chunk(t, k);
                end
                else
                begin
                    t.skipping_space = 1'b1;
                end
            end
            else
            begin
                t = open_chunk(t, k);
            end
        end

        // take in the current byte
        if (t.skipping_space && !is_blank(c))
        begin
            t = open_chunk(t, k);
        end
        if (!t.skipping_space)
        begin
            if (is_mark(c))
            begin
                t.boundary_seen            = 1'b1;
                t.boundary_end             = k + pos_t'(1);
                t.text_after_boundary_seen = 1'b0;
                t.nonspace_end             = k + pos_t'(1);
            end
            else if (is_blank(c))
            begin
                t.space_seen     = 1'b1;
                t.space_position = k;
            end
            else
            begin
                t.nonspace_end = k + pos_t'(1);
                if (t.boundary_seen && !t.text_after_boundary_seen)
                begin
                    t.first_text_after_boundary = k;
                    t.text_after_boundary_seen  = 1'b1;
                end
            end
        end
        t.byte_position = k + pos_t'(1);

        if (item_reg.last_byte)
        begin
            len = t.nonspace_end - t.chunk_start;
            if (!t.skipping_space && len != '0 && max_chunk_size_reg != '0
                && t.chunks_emitted < max_chunks_reg)
            begin
                if (n == 2'd0)
                begin
                    r0 = make_chunk(t.chunk_start, len);
                end
                else
                begin
                    r1 = make_chunk(t.chunk_start, len);
                end
                n = n + 2'd1;
            end
            unique case (n)
                2'd0:
                begin
                    r0             = '0;
                    r0.end_of_text = 1'b1;
                    n              = 2'd1;
                end
                2'd1:    r0.end_of_text = 1'b1;
                default: r1.end_of_text = 1'b1;
            endcase
            t = TRACK_RESET;
        end

        track_next = t;
        push.count  = fire ? n : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            track_reg          <= TRACK_RESET;
            max_chunk_size_reg <= MAX_CHUNK_SIZE_RESET;
            max_chunks_reg     <= MAX_CHUNKS_RESET;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                track_reg <= track_next;
            end
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MAX_CHUNK_SIZE)
                begin
                    max_chunk_size_reg <= cfg_data;
                end
                else if (cfg_index == CFG_MAX_CHUNKS)
                begin
                    max_chunks_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= text;
        end
    end

    // the final byte always leaves at least the end marker
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.last_byte |-> push.count != 2'd0)
        else $error("final byte produced no result item");

    a_push_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> push.count == 2'd0)
        else $error("result item pushed without a step");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.last_byte |=> track_reg.skipping_space
            && track_reg.byte_position == '0 && track_reg.chunks_emitted == '0)
        else $error("trackers not cleared after final byte");

endmodule

/* hw/rtl/tcc_fifo.sv */
// ----------------------------------------------------------------------------
// tcc_fifo : result queue
// Four-entry queue taking up to two chunk items a cycle and handing out one while chunk_stall is low.
// ----------------------------------------------------------------------------
module tcc_fifo
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chunk_push_t push,
    output logic        room,
    output logic        chunk_valid,
    input  logic        chunk_stall,
    output chunk_item_t chunk
);

    localparam int DEPTH = 4;

    chunk_item_t mem_reg [DEPTH];
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        pop;

    assign room        = count_reg <= 3'(DEPTH - 2);
    assign chunk_valid = count_reg != 3'd0;
    assign chunk       = mem_reg[rd_ptr_reg];
    assign pop         = chunk_valid && !chunk_stall;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        wr_ptr_next = wr_ptr_reg + push.count;
        count_next  = count_reg + 3'(push.count) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> 3'(push.count) + count_reg <= 3'(DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("result queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 3'd1)
        else $error("result queue count did not drop on a lone pop");

endmodule

/* hw/rtl/text_clause_chunker_top.sv */
// ----------------------------------------------------------------------------
// text_clause_chunker_top : clause-aware text chunker
// Cuts a byte stream into chunks of bounded size, preferring clause marks,
// then whitespace, then a hard cut, and reports each as offset and length.
//
//   channel  direction  handshake            payload
//   text     in         text_valid/stall     text_byte, last_byte
//   chunk    out        chunk_valid/stall    offset, length, present, end
//   cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
// One byte per cycle while text_stall is low: a byte is held in the input
// register, then the step logic updates the trackers and writes up to two
// chunk items into a four-entry queue; a result item is offered on chunk_valid
// once it is written there and is taken while chunk_stall is low.
// Bytes are stalled only while the queue has fewer than two free entries.
// Reset restores the trackers and the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module text_clause_chunker_top
    import tcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_stall,
    input  text_item_t                text,
    output logic                      chunk_valid,
    input  logic                      chunk_stall,
    output chunk_item_t               chunk,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    chunk_push_t push;
    logic        room;

    assign cfg_ready = 1'b1;

    tcc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .room       (room),
        .push       (push)
    );

    tcc_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .chunk_valid (chunk_valid),
        .chunk_stall (chunk_stall),
        .chunk       (chunk)
    );

endmodule
